// File: hw/rtl/lsep_pkg.sv
package lsep_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned MLEN_W    = 4;
   localparam int unsigned PATTERN_W = 64;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned CNT_W     = 5;
   localparam int unsigned CSR_IDX_W = 2;

   // bit counter value that closes one hidden character
   localparam logic [CNT_W-1:0] CHAR_BITS = 5'd8;

   localparam logic [BYTE_W-1:0]    HEADER_SKIP_RESET   = 8'd54;
   localparam logic [MLEN_W-1:0]    MAGIC_LENGTH_RESET  = 4'd2;
   localparam logic [PATTERN_W-1:0] MAGIC_PATTERN_RESET = 64'h2322;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SKIP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_PATTERN = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SIG_OK    = 3'd0,
      KIND_SIG_BAD   = 3'd1,
      KIND_EXT_LEN   = 3'd2,
      KIND_EXT_CHAR  = 3'd3,
      KIND_PAY_LEN   = 3'd4,
      KIND_PAY_BYTE  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] image_byte;
      logic              restart;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    header_skip;
      logic [MLEN_W-1:0]    magic_length;
      logic [PATTERN_W-1:0] magic_pattern;
   } cfg_type;

   typedef struct packed {
      logic              emit;
      kind_type          kind;
      logic [WORD_W-1:0] value;
      logic              last;
   } result_type;

endpackage

// File: hw/rtl/lsep_core.sv
module lsep_core #(
   parameter int unsigned MAX_MAGIC_CHARS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lsep_pkg::item_type  item,
   input  lsep_pkg::cfg_type   cfg,
   output lsep_pkg::result_type result
);
   import lsep_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_MAGIC   = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_EXTCHR  = 3'd3,
      PH_PAYLEN  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   phase_type           phase_ff,  phase_in;
   logic [BYTE_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [WORD_W-1:0]   acc_ff,    acc_in;
   logic [WORD_W-1:0]   remain_ff, remain_in;
   logic [MLEN_W-1:0]   midx_ff,   midx_in;
   logic                mismatch_ff, mismatch_in;

   always_comb begin
      logic                stop;
      logic                bit_in;
      logic [MLEN_W-1:0]   mlen;
      logic [MLEN_W-1:0]   sel;
      logic [BYTE_W-1:0]   expect_ch;
      logic [WORD_W-1:0]   len;

      phase_in    = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      bit_cnt_in  = bit_cnt_ff;
      acc_in      = acc_ff;
      remain_in   = remain_ff;
      midx_in     = midx_ff;
      mismatch_in = mismatch_ff;
      result      = '0;
      stop        = 1'b0;
      bit_in      = item.image_byte[0];
      sel         = '0;
      expect_ch   = '0;
      len         = '0;
      mlen = (cfg.magic_length > MAX_MAGIC_CHARS) ? MLEN_W'(MAX_MAGIC_CHARS)
                                                   : cfg.magic_length;

      if (item.restart) begin
         phase_in    = PH_HEADER;
         hdr_cnt_in  = '0;
         bit_cnt_in  = '0;
         acc_in      = '0;
         remain_in   = '0;
         midx_in     = '0;
         mismatch_in = 1'b0;
      end

      if (phase_in == PH_HEADER) begin
         if (hdr_cnt_in < cfg.header_skip) begin
            hdr_cnt_in = hdr_cnt_in + 1'b1;
            stop       = 1'b1;
         end else begin
            phase_in = PH_MAGIC;
         end
      end

      if (!stop && phase_in == PH_MAGIC) begin
         if (midx_in >= mlen) begin
            // signature already complete: report it, the bit starts the length
            result.emit = 1'b1;
            result.kind = mismatch_in ? KIND_SIG_BAD : KIND_SIG_OK;
            if (mismatch_in) begin
               phase_in = PH_DONE;
               stop     = 1'b1;
            end else begin
               phase_in   = PH_EXTLEN;
               bit_cnt_in = '0;
               acc_in     = '0;
            end
         end else begin
            acc_in     = {acc_in[WORD_W-2:0], bit_in};
            bit_cnt_in = bit_cnt_in + 1'b1;
            if (bit_cnt_in == CHAR_BITS) begin
               bit_cnt_in = '0;
               sel        = mlen - 1'b1 - midx_in;
               expect_ch  = BYTE_W'(cfg.magic_pattern >> {sel[2:0], 3'b000});
               if (acc_in[BYTE_W-1:0] != expect_ch)
                  mismatch_in = 1'b1;
               midx_in = midx_in + 1'b1;
               acc_in  = '0;
               if (midx_in >= mlen) begin
                  phase_in    = mismatch_in ? PH_DONE : PH_EXTLEN;
                  result.emit = 1'b1;
                  result.kind = mismatch_in ? KIND_SIG_BAD : KIND_SIG_OK;
               end
            end
            stop = 1'b1;
         end
      end

      if (!stop) begin
         unique case (phase_in)
            PH_EXTLEN, PH_PAYLEN: begin
               acc_in     = {acc_in[WORD_W-2:0], bit_in};
               bit_cnt_in = bit_cnt_in + 1'b1;
               if (bit_cnt_in == '0) begin
                  // top bit set reads as an empty field
                  len          = acc_in[WORD_W-1] ? '0 : acc_in;
                  acc_in       = '0;
                  remain_in    = len;
                  result.emit  = 1'b1;
                  result.value = len;
                  if (phase_in == PH_EXTLEN) begin
                     result.kind = KIND_EXT_LEN;
                     phase_in    = (len != '0) ? PH_EXTCHR : PH_PAYLEN;
                  end else begin
                     result.kind = KIND_PAY_LEN;
                     result.last = (len == '0);
                     phase_in    = (len != '0) ? PH_PAYLOAD : PH_DONE;
                  end
               end
            end
            PH_EXTCHR, PH_PAYLOAD: begin
               acc_in     = {acc_in[WORD_W-2:0], bit_in};
               bit_cnt_in = bit_cnt_in + 1'b1;
               if (bit_cnt_in == CHAR_BITS) begin
                  bit_cnt_in   = '0;
                  result.emit  = 1'b1;
                  result.value = WORD_W'(acc_in[BYTE_W-1:0]);
                  acc_in       = '0;
                  if (remain_in != '0)
                     remain_in = remain_in - 1'b1;
                  if (phase_in == PH_EXTCHR) begin
                     result.kind = KIND_EXT_CHAR;
                     if (remain_in == '0)
                        phase_in = PH_PAYLEN;
                  end else begin
                     result.kind = KIND_PAY_BYTE;
                     if (remain_in == '0) begin
                        result.last = 1'b1;
                        phase_in    = PH_DONE;
                     end
                  end
               end
            end
            default: begin
               // finished or rejected image: drop bytes until restart
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_cnt_ff  <= '0;
         bit_cnt_ff  <= '0;
         acc_ff      <= '0;
         remain_ff   <= '0;
         midx_ff     <= '0;
         mismatch_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         bit_cnt_ff  <= bit_cnt_in;
         acc_ff      <= acc_in;
         remain_ff   <= remain_in;
         midx_ff     <= midx_in;
         mismatch_ff <= mismatch_in;
      end
   end

endmodule

// File: hw/rtl/lsb_stego_payload_extractor_unit.sv
// LSB steganography payload extractor.
// req_ channel: one cover image byte per transfer, tdata = image_byte,
// tuser = restart (set on the first byte of each image).
// rsp_ channel: one tagged result per decoded field: tuser = kind
// (signature ok/bad, extension length/char, payload length/byte),
// tdata = value, tlast on the final payload byte or an empty payload.
// Most bytes produce no result; they only shift a hidden bit in, or are skipped.
// csr_ channel: register writes (0 header skip, 1 signature length,
// 2 signature pattern), always ready; write only while no byte is in flight.
// A byte accepted on req_ goes through the input register and the result register
// to rsp_. Throughput: one byte per cycle while the receiver does not stall, set by
// the single parse step that updates the decode state once per byte.
// An input register and an output register hold one item each; when the
// receiver stalls with a result pending, req_tready drops once the input
// register is also full, and nothing is lost.
// Reset clears the decode state, empties both registers and loads the
// default header skip of 54 and a two-character signature.
module lsb_stego_payload_extractor_unit #(
   parameter int unsigned MAX_MAGIC_CHARS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lsep_pkg::BYTE_W-1:0]         req_tdata,  // [7:0] image_byte
   input  logic                                req_tuser,  // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lsep_pkg::WORD_W-1:0]         rsp_tdata,  // [31:0] value
   output logic [lsep_pkg::KIND_W-1:0]         rsp_tuser,  // [2:0] kind
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsep_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsep_pkg::PATTERN_W-1:0]      csr_data
);
   import lsep_pkg::*;

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type step_res;
   logic       rsp_valid_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   kind_type   rsp_kind_ff;
   logic       rsp_last_ff;
   logic       advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_skip   <= HEADER_SKIP_RESET;
         cfg_ff.magic_length  <= MAGIC_LENGTH_RESET;
         cfg_ff.magic_pattern <= MAGIC_PATTERN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HEADER_SKIP:   cfg_ff.header_skip   <= csr_data[BYTE_W-1:0];
            CSR_MAGIC_LENGTH:  cfg_ff.magic_length  <= csr_data[MLEN_W-1:0];
            CSR_MAGIC_PATTERN: cfg_ff.magic_pattern <= csr_data;
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.image_byte <= req_tdata;
         item_ff.restart    <= req_tuser;
      end
   end

   lsep_core #(
      .MAX_MAGIC_CHARS(MAX_MAGIC_CHARS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (in_valid_ff && advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (step_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && step_res.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && step_res.emit) begin
         rsp_value_ff <= step_res.value;
         rsp_kind_ff  <= step_res.kind;
         rsp_last_ff  <= step_res.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: bench/lsep_result_checker.sv
`timescale 1ns / 100ps

module lsep_result_checker
   import lsep_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [WORD_W-1:0]    rsp_tdata,
   input  logic [KIND_W-1:0]    rsp_tuser,
   input  logic                 rsp_tlast,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PATTERN_W-1:0] csr_data,
   output int unsigned          fail_count,
   output int unsigned          open_count
);

   localparam int unsigned MAX_SIG = 8;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_SIGNATURE,
      ST_EXT_LEN,
      ST_EXT_CHAR,
      ST_PAY_LEN,
      ST_PAY_BYTE,
      ST_DONE
   } parse_state_type;

   typedef struct {
      kind_type          kind;
      logic [WORD_W-1:0] value;
      logic              last;
   } decoded_type;

   decoded_type decoded_q[$];

   logic [BYTE_W-1:0]    cfg_skip;
   logic [MLEN_W-1:0]    cfg_sig_len;
   logic [PATTERN_W-1:0] cfg_sig_pat;

   parse_state_type      prs_state;
   logic [7:0]           hdr_seen;
   logic [CNT_W-1:0]     bit_pos;
   logic [WORD_W-1:0]    shift_reg;
   logic [WORD_W-1:0]    left_count;
   logic [MLEN_W-1:0]    sig_pos;
   logic                 sig_bad;

   task automatic clear_parse();
      prs_state  = ST_HEADER;
      hdr_seen   = '0;
      bit_pos    = '0;
      shift_reg  = '0;
      left_count = '0;
      sig_pos    = '0;
      sig_bad    = 1'b0;
   endtask

   // Walk one image byte through the parser; got is set when it yields a result.
   task automatic decode_byte(input logic [BYTE_W-1:0] img, input logic first,
                              output logic got, output decoded_type res);
      logic              lsb;
      int unsigned       eff;
      logic [7:0]        ch;
      logic [7:0]        want;
      logic [WORD_W-1:0] len;
      lsb = img[0];
      got = 1'b0;
      res.kind = KIND_SIG_OK;
      res.value = '0;
      res.last = 1'b0;
      if (first)
         clear_parse();
      if (prs_state == ST_HEADER) begin
         if (hdr_seen < cfg_skip) begin
            hdr_seen = hdr_seen + 8'd1;
            return;
         end
         prs_state = ST_SIGNATURE;
      end
      if (prs_state == ST_SIGNATURE) begin
         eff = (cfg_sig_len > MAX_SIG) ? MAX_SIG : cfg_sig_len;
         if (sig_pos >= eff) begin
            // signature already complete: report it, this bit opens the length
            got = 1'b1;
            res.kind = sig_bad ? KIND_SIG_BAD : KIND_SIG_OK;
            if (sig_bad) begin
               prs_state = ST_DONE;
               return;
            end
            prs_state = ST_EXT_LEN;
            bit_pos   = '0;
            shift_reg = '0;
         end else begin
            shift_reg = {shift_reg[WORD_W-2:0], lsb};
            bit_pos   = bit_pos + 1'b1;
            if (bit_pos != CHAR_BITS)
               return;
            bit_pos = '0;
            ch   = shift_reg[7:0];
            want = 8'(cfg_sig_pat >> (((eff - 1 - sig_pos) * 8) & 63));
            if (ch != want)
               sig_bad = 1'b1;
            sig_pos   = sig_pos + 1'b1;
            shift_reg = '0;
            if (sig_pos < eff)
               return;
            prs_state = sig_bad ? ST_DONE : ST_EXT_LEN;
            got = 1'b1;
            res.kind = sig_bad ? KIND_SIG_BAD : KIND_SIG_OK;
            return;
         end
      end
      case (prs_state)
         ST_EXT_LEN, ST_PAY_LEN: begin
            shift_reg = {shift_reg[WORD_W-2:0], lsb};
            bit_pos   = bit_pos + 1'b1;
            if (bit_pos != '0)
               return;
            len = shift_reg[WORD_W-1] ? '0 : shift_reg;
            shift_reg  = '0;
            left_count = len;
            got = 1'b1;
            res.value = len;
            if (prs_state == ST_EXT_LEN) begin
               res.kind  = KIND_EXT_LEN;
               prs_state = (len != 0) ? ST_EXT_CHAR : ST_PAY_LEN;
            end else begin
               res.kind  = KIND_PAY_LEN;
               res.last  = (len == 0);
               prs_state = (len != 0) ? ST_PAY_BYTE : ST_DONE;
            end
         end
         ST_EXT_CHAR, ST_PAY_BYTE: begin
            shift_reg = {shift_reg[WORD_W-2:0], lsb};
            bit_pos   = bit_pos + 1'b1;
            if (bit_pos != CHAR_BITS)
               return;
            bit_pos = '0;
            ch = shift_reg[7:0];
            shift_reg = '0;
            if (left_count != 0)
               left_count = left_count - 1;
            got = 1'b1;
            res.value = {24'd0, ch};
            if (prs_state == ST_EXT_CHAR) begin
               res.kind = KIND_EXT_CHAR;
               if (left_count == 0)
                  prs_state = ST_PAY_LEN;
            end else begin
               res.kind = KIND_PAY_BYTE;
               if (left_count == 0) begin
                  res.last  = 1'b1;
                  prs_state = ST_DONE;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      logic        got;
      decoded_type res;
      decoded_type exp_res;
      if (reset) begin
         cfg_skip    = HEADER_SKIP_RESET;
         cfg_sig_len = MAGIC_LENGTH_RESET;
         cfg_sig_pat = MAGIC_PATTERN_RESET;
         clear_parse();
         decoded_q.delete();
         fail_count  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: result with nothing expected: kind %0d value %h last %b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               fail_count = fail_count + 1;
            end else begin
               exp_res = decoded_q.pop_front();
               if (rsp_tuser !== exp_res.kind) begin
                  $display("%0t: kind mismatch: expected %0d, actual %0d",
                           $time, exp_res.kind, rsp_tuser);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata !== exp_res.value) begin
                  $display("%0t: value mismatch: expected %h, actual %h",
                           $time, exp_res.value, rsp_tdata);
                  fail_count = fail_count + 1;
               end
               if (rsp_tlast !== exp_res.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $time, exp_res.last, rsp_tlast);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADER_SKIP:   cfg_skip    = csr_data[BYTE_W-1:0];
               CSR_MAGIC_LENGTH:  cfg_sig_len = csr_data[MLEN_W-1:0];
               CSR_MAGIC_PATTERN: cfg_sig_pat = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser, got, res);
            if (got)
               decoded_q.push_back(res);
         end
      end
      open_count = decoded_q.size();
   end

endmodule

// File: bench/tb_lsb_stego_payload_extractor_unit.sv
`timescale 1ns / 100ps

module tb_lsb_stego_payload_extractor_unit;
   import lsep_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned SENT_ITEMS  = 1400;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [WORD_W-1:0]    rsp_tdata;
   logic [KIND_W-1:0]    rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PATTERN_W-1:0] csr_data = '0;

   int unsigned          fail_count;
   int unsigned          open_count;
   int unsigned          cycle_count = 0;

   // stimulus-side copy of the registers, used only to build images
   logic [BYTE_W-1:0]    stim_skip    = HEADER_SKIP_RESET;
   logic [MLEN_W-1:0]    stim_sig_len = MAGIC_LENGTH_RESET;
   logic [PATTERN_W-1:0] stim_sig_pat = MAGIC_PATTERN_RESET;

   int                   burst_left   = 0;
   int                   gap_max      = 6;
   int unsigned          byte_budget  = 0;
   logic                 restart_next = 1'b0;
   int unsigned          sent_items   = 0;
   logic                 after_cut    = 1'b0;

   logic [1:0]           ready_mode = 2'd0;
   logic [7:0]           ready_tick = 8'd0;

   lsb_stego_payload_extractor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lsep_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** lsb_stego_payload_extractor_unit: FAILED **");
         $finish;
      end
   end

   // receiver stall pattern, switching style whenever the 8-bit tick counter wraps
   always @(negedge clock) begin
      ready_tick <= ready_tick + 8'd1;
      if (ready_tick == 8'd0)
         ready_mode <= 2'($urandom_range(0, 3));
      case (ready_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= ready_tick[0];
         default: rsp_tready <= (ready_tick[3:0] < 4'd4);
      endcase
   end

   task automatic send_item(input logic [BYTE_W-1:0] data, input logic first);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left = burst_left - 1;
      sent_items = sent_items + 1;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] data);
      if (byte_budget == 0)
         return;
      byte_budget = byte_budget - 1;
      send_item(data, restart_next);
      restart_next = 1'b0;
   endtask

   // hide a field in the low bits of consecutive bytes, msb first
   task automatic send_field(input logic [WORD_W-1:0] val, input int width);
      for (int i = width - 1; i >= 0; i--)
         send_byte({7'($urandom), val[i]});
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (open_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_length(input int unsigned max, input bit huge);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return $urandom | 32'h8000_0000;
         2: return huge ? ($urandom & 32'h7FFF_FFFF) : max;
         default: return $urandom_range(1, max);
      endcase
   endfunction

   task automatic send_noise(input bit allow_restart);
      repeat ($urandom_range(4, 40))
         send_item(8'($urandom), allow_restart && ($urandom_range(0, 15) == 0));
   endtask

   task automatic send_image(input bit truncate);
      int unsigned       eff;
      int unsigned       ext_len;
      int unsigned       pay_len;
      logic [WORD_W-1:0] raw;
      logic [7:0]        ch;
      logic [7:0]        want;
      bit                sig_ok;
      byte_budget  = truncate ? $urandom_range(1, 90) : 32'h4000_0000;
      restart_next = 1'b1;
      repeat (stim_skip) send_byte(8'($urandom));
      eff = (stim_sig_len > 8) ? 8 : stim_sig_len;
      sig_ok = 1'b1;
      for (int unsigned i = 0; i < eff; i++) begin
         want = 8'(stim_sig_pat >> (8 * (eff - 1 - i)));
         ch = want;
         if ($urandom_range(0, 11) == 0)
            ch = 8'($urandom);
         if (ch != want)
            sig_ok = 1'b0;
         send_field({24'd0, ch}, 8);
      end
      if (!sig_ok) begin
         // everything after a bad signature is dropped by the block
         repeat ($urandom_range(0, 6)) send_byte(8'($urandom));
         return;
      end
      raw = pick_length(4, truncate);
      send_field(raw, 32);
      ext_len = raw[31] ? 0 : raw;
      if ($urandom_range(0, 5) == 0)
         drain_results();
      for (int unsigned j = 0; j < ext_len && byte_budget > 0; j++)
         send_field(32'($urandom_range(0, 255)), 8);
      raw = pick_length(12, truncate);
      send_field(raw, 32);
      pay_len = raw[31] ? 0 : raw;
      for (int unsigned j = 0; j < pay_len && byte_budget > 0; j++)
         send_field(32'($urandom_range(0, 255)), 8);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
   endtask

   initial begin
      logic [7:0] bad_char;
      logic       b;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one image under the reset register values
      send_image(1'b0);
      drain_results();

      // one-character signature that does not match, then ignored bytes
      stim_skip    = 8'd1;
      stim_sig_len = 4'd1;
      stim_sig_pat = 64'hFFFF_FFFF_FFFF_FFC3;
      write_reg(CSR_HEADER_SKIP, {56'd0, stim_skip});
      write_reg(CSR_MAGIC_LENGTH, {60'd0, stim_sig_len});
      write_reg(CSR_MAGIC_PATTERN, stim_sig_pat);
      bad_char = 8'h3C;
      send_item(8'hFE, 1'b1);
      for (int i = 7; i >= 0; i--) begin
         b = bad_char[i];
         if (i % 2 == 0)
            send_item(b ? 8'hFF : 8'h00, 1'b0);
         else
            send_item(b ? 8'h01 : 8'hFE, 1'b0);
      end
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h81, 1'b0);
      drain_results();

      while (sent_items < SENT_ITEMS) begin
         drain_results();
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 9))
               0: stim_skip = 8'd0;
               1: stim_skip = 8'd255;
               2: stim_skip = HEADER_SKIP_RESET;
               default: stim_skip = 8'($urandom_range(0, 12));
            endcase
            write_reg(CSR_HEADER_SKIP, {56'd0, stim_skip});
         end
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0: stim_sig_len = 4'd0;
               1: stim_sig_len = 4'd8;
               2: stim_sig_len = 4'($urandom_range(9, 15));
               default: stim_sig_len = 4'($urandom_range(1, 4));
            endcase
            write_reg(CSR_MAGIC_LENGTH, {60'd0, stim_sig_len});
         end
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0: stim_sig_pat = '0;
               1: stim_sig_pat = '1;
               default: stim_sig_pat = {$urandom, $urandom};
            endcase
            write_reg(CSR_MAGIC_PATTERN, stim_sig_pat);
         end
         // carry on a cut-off image under the new settings
         if (after_cut && $urandom_range(0, 1) == 0)
            send_noise(1'b0);
         after_cut = 1'b0;
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 7))
               0: send_noise(1'b1);
               1: begin
                  send_image(1'b1);
                  after_cut = 1'b1;
               end
               default: begin
                  send_image(1'b0);
                  after_cut = 1'b0;
               end
            endcase
         end
      end

      drain_results();
      if (fail_count == 0 && open_count == 0)
         $display("** lsb_stego_payload_extractor_unit: PASSED **");
      else
         $display("** lsb_stego_payload_extractor_unit: FAILED **");
      $finish;
   end

endmodule
